/* rtl/trt_pkg.sv */
// shared types and constants of the touch report tracker
package trt_pkg;

    localparam int NumPts = 5;
    localparam int IdxW   = 3;
    localparam int CrdW   = 16;
    localparam int ModeW  = 8;
    localparam int FlagW  = 8;
    localparam int CntW   = 4;

    // input tdata layout: mode byte, status byte, then a/b word pairs per point
    localparam int InDataW  = 2 * ModeW + 2 * CrdW * NumPts;
    localparam int RawBase  = 2 * ModeW;

    // output tdata layout: index, x, y, flags, padded to whole bytes
    localparam int OutBits  = IdxW + 2 * CrdW + FlagW;
    localparam int OutDataW = ((OutBits + 7) / 8) * 8;
    localparam int OutUserW = 3;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [IdxW-1:0] LastIdx = IdxW'(NumPts - 1);

    localparam logic [FlagW-1:0] FlagsActive = 8'hC0;
    localparam logic [FlagW-1:0] PressBit    = 8'h80;
    localparam logic [FlagW-1:0] ClrPress    = 8'h7F;
    localparam logic [FlagW-1:0] KeepOnClr   = 8'hE0;
    localparam logic [ModeW-1:0] RelMask     = 8'h8F;
    localparam logic [ModeW-1:0] RelCode     = 8'h80;
    localparam logic [ModeW-1:0] RollbackMode = 8'h80;

    localparam logic [7:0] PollCap     = 8'd240;
    localparam logic [7:0] PollRestart = 8'd10;
    localparam logic [7:0] SampleBelow = 8'd10;
    localparam logic [3:0] ModLast     = 4'd9;
    localparam logic [CntW-1:0] CntLimit = 4'd6;
    localparam logic [CntW-1:0] CntOne   = 4'd1;
    localparam logic [CntW-1:0] CntAll   = CntW'(NumPts);

    localparam logic [CrdW-1:0] CrdClear = 16'hFFFF;

    // reset values of the configuration registers
    localparam logic [1:0]      RstScanDir = 2'd1;
    localparam logic [CrdW-1:0] RstWidth   = 16'd320;
    localparam logic [CrdW-1:0] RstHeight  = 16'd480;
    localparam logic [CrdW-1:0] RstShort   = 16'd320;
    localparam logic [CrdW-1:0] RstLong    = 16'd480;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SCAN_DIR = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_HEIGHT   = 3'd2,
        CFG_SHORT    = 3'd3,
        CFG_LONG     = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIR_ROTATE     = 2'd0,
        DIR_DIRECT     = 2'd1,
        DIR_MIRROR     = 2'd2,
        DIR_ROTATE_REV = 2'd3
    } scan_dir_t;

    typedef struct packed {
        logic [1:0]      scan_dir;
        logic [CrdW-1:0] width;
        logic [CrdW-1:0] height;
        logic [CrdW-1:0] short_side;
        logic [CrdW-1:0] long_side;
    } trt_cfg_t;

    typedef struct packed {
        logic [FlagW-1:0] flags;
        logic             scan_valid;
        logic             clear_req;
        logic             sampled;
    } trt_status_t;

    // one classified poll: slot writes plus the flags to report
    typedef struct packed {
        trt_status_t                  status;
        logic [NumPts-1:0]            wr;
        logic                         backup;
        logic [NumPts-1:0][CrdW-1:0]  px;
        logic [NumPts-1:0][CrdW-1:0]  py;
    } trt_cmd_t;

endpackage

/* rtl/trt_front.sv */
// front end: poll counter, status sampling, flag update and coordinate transform
module trt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [trt_pkg::InDataW-1:0]   in_data,
    input  trt_pkg::trt_cfg_t             cfg,
    input  logic                          room,
    output logic                          push,
    output trt_pkg::trt_cmd_t             cmd
);

    logic [7:0]                  poll_reg, poll_next;
    logic [3:0]                  mod_reg, mod_next;
    logic [trt_pkg::FlagW-1:0]   flag_reg, flag_next;

    logic [7:0]                  pc, pc_a;
    logic [3:0]                  mod_inc, mod_a;
    logic                        sampled, load, oob, rollback, release_hit, rel_clr;
    logic [trt_pkg::ModeW-1:0]   mode, mode_a;
    logic [trt_pkg::CntW-1:0]    cnt;
    logic [trt_pkg::NumPts-1:0]  mask;
    logic [trt_pkg::FlagW-1:0]   flag_a, flag_b;
    logic [trt_pkg::NumPts-1:0][trt_pkg::CrdW-1:0] ra, rb, tx, ty;

    assign in_ready = room;
    assign push     = in_valid & room;

    always_comb
    begin
        for (int i = 0; i < trt_pkg::NumPts; i++)
        begin
            ra[i] = in_data[trt_pkg::RawBase + 2*trt_pkg::CrdW*i +: trt_pkg::CrdW];
            rb[i] = in_data[trt_pkg::RawBase + 2*trt_pkg::CrdW*i + trt_pkg::CrdW +:
                            trt_pkg::CrdW];
            mask[i] = (cnt > trt_pkg::CntW'(i));
            unique case (trt_pkg::scan_dir_t'(cfg.scan_dir))
                trt_pkg::DIR_ROTATE:
                begin
                    tx[i] = rb[i];
                    ty[i] = cfg.short_side - ra[i];
                end
                trt_pkg::DIR_DIRECT:
                begin
                    tx[i] = ra[i];
                    ty[i] = rb[i];
                end
                trt_pkg::DIR_MIRROR:
                begin
                    tx[i] = cfg.short_side - ra[i];
                    ty[i] = cfg.long_side - rb[i];
                end
                default:
                begin
                    tx[i] = cfg.long_side - rb[i];
                    ty[i] = ra[i];
                end
            endcase
        end
    end

    always_comb
    begin
        pc      = poll_reg + 8'd1;
        mod_inc = (mod_reg == trt_pkg::ModLast) ? 4'd0 : mod_reg + 4'd1;
        sampled = (mod_inc == 4'd0) || (pc < trt_pkg::SampleBelow);
        mode    = sampled ? in_data[trt_pkg::ModeW +: trt_pkg::ModeW]
                          : in_data[0 +: trt_pkg::ModeW];
        cnt     = mode[trt_pkg::CntW-1:0];
        load    = sampled && (cnt != '0) && (cnt < trt_pkg::CntLimit);
        oob     = (tx[0] > cfg.width) || (ty[0] > cfg.height);
        rollback = load && oob && (cnt == trt_pkg::CntOne);

        if (load && !rollback)
            flag_a = trt_pkg::FlagsActive | trt_pkg::FlagW'(mask);
        else
            flag_a = flag_reg;
        mode_a = rollback ? trt_pkg::RollbackMode : mode;
        pc_a   = (load && !rollback) ? 8'd0 : pc;
        mod_a  = (load && !rollback) ? 4'd0 : mod_inc;

        // release tracking on a ready byte with no points
        release_hit = ((mode_a & trt_pkg::RelMask) == trt_pkg::RelCode);
        rel_clr     = release_hit && !flag_a[trt_pkg::FlagW-1];
        if (!release_hit)
            flag_b = flag_a;
        else if (flag_a[trt_pkg::FlagW-1])
            flag_b = flag_a & trt_pkg::ClrPress;
        else
            flag_b = flag_a & trt_pkg::KeepOnClr;

        if (pc_a > trt_pkg::PollCap)
        begin
            poll_next = trt_pkg::PollRestart;
            mod_next  = 4'd0;
        end
        else
        begin
            poll_next = pc_a;
            mod_next  = mod_a;
        end
        flag_next = flag_b;

        for (int i = 0; i < trt_pkg::NumPts; i++)
        begin
            cmd.wr[i] = load && mask[i];
            cmd.px[i] = tx[i];
            cmd.py[i] = ty[i];
        end
        cmd.wr[0] = (load && !rollback) || rel_clr;
        if (rel_clr)
        begin
            cmd.px[0] = trt_pkg::CrdClear;
            cmd.py[0] = trt_pkg::CrdClear;
        end
        else if (oob)
        begin
            cmd.px[0] = tx[1];
            cmd.py[0] = ty[1];
        end
        cmd.backup = load && (cnt < trt_pkg::CntAll);

        cmd.status.flags      = flag_b;
        cmd.status.scan_valid = load;
        cmd.status.clear_req  = sampled && mode[trt_pkg::ModeW-1] &&
                                (cnt < trt_pkg::CntLimit);
        cmd.status.sampled    = sampled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_reg <= '0;
            mod_reg  <= '0;
            flag_reg <= '0;
        end
        else if (push)
        begin
            poll_reg <= poll_next;
            mod_reg  <= mod_next;
            flag_reg <= flag_next;
        end
    end

endmodule

/* rtl/trt_cmd_queue.sv */
// two-entry queue of classified polls between front and back
module trt_cmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  trt_pkg::trt_cmd_t  push_cmd,
    output logic               room,
    input  logic               pop,
    output logic               avail,
    output trt_pkg::trt_cmd_t  head
);

    trt_pkg::trt_cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign room  = (count_reg != 2'd2);
    assign avail = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/trt_back.sv */
// back end: point slots and one point result per cycle, unless out_ready stalls it, into the output register
module trt_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            avail,
    input  trt_pkg::trt_cmd_t               head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [trt_pkg::OutDataW-1:0]    out_data,
    output logic [trt_pkg::OutUserW-1:0]    out_user,
    output logic                            out_last
);

    logic [trt_pkg::CrdW-1:0] sx_reg [trt_pkg::NumPts];
    logic [trt_pkg::CrdW-1:0] sy_reg [trt_pkg::NumPts];
    trt_pkg::trt_status_t     stat_reg;
    logic                     busy_reg, busy_next;
    logic [trt_pkg::IdxW-1:0] idx_reg, idx_next;
    logic                     valid_reg, valid_next;
    logic [trt_pkg::OutDataW-1:0] data_reg;
    logic [trt_pkg::OutUserW-1:0] user_reg;
    logic                     last_reg;
    logic                     load_out, last_load;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        load_out   = busy_reg && (!valid_reg || out_ready);
        last_load  = load_out && (idx_reg == trt_pkg::LastIdx);
        pop        = avail && (!busy_reg || last_load);
        busy_next  = pop ? 1'b1 : (last_load ? 1'b0 : busy_reg);
        idx_next   = pop ? '0 : (load_out ? idx_reg + 1'b1 : idx_reg);
        valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            for (int i = 0; i < trt_pkg::NumPts; i++)
            begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
            end
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            if (pop)
            begin
                for (int i = 0; i < trt_pkg::NumPts; i++)
                begin
                    if (head.wr[i])
                    begin
                        sx_reg[i] <= head.px[i];
                        sy_reg[i] <= head.py[i];
                    end
                end
                // backup slot keeps the previous first point unless overwritten
                if (!head.wr[trt_pkg::NumPts-1] && head.backup)
                begin
                    sx_reg[trt_pkg::NumPts-1] <= sx_reg[0];
                    sy_reg[trt_pkg::NumPts-1] <= sy_reg[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            stat_reg <= head.status;
        if (load_out)
        begin
            data_reg <= trt_pkg::OutDataW'({stat_reg.flags, sy_reg[idx_reg],
                                            sx_reg[idx_reg], idx_reg});
            user_reg <= {stat_reg.sampled, stat_reg.clear_req, stat_reg.scan_valid};
            last_reg <= (idx_reg == trt_pkg::LastIdx);
        end
    end

endmodule

/* rtl/touch_report_tracker.sv */
// top level of the touch report tracker: configuration registers and stream ports
// Each poll transaction on the s_ side advances the poll counter, samples the device
// status when due, rebuilds the point flags and transforms the raw coordinates by the
// scan direction; it then yields five point transactions on the m_ side, index 0 to 4,
// the last one marked by m_tlast. The front end classifies a poll in the cycle it is
// accepted and hands it through a two-entry queue to the back end, which updates the
// point slots and sends one point result per cycle, unless m_tready stalls, through an
// output register. The back end sets the pace; the queue lets up to two polls wait
// while results drain, so a new poll is taken before the last one is through.
// Configuration writes are taken at any time (cfg_ready is always high) but must only
// be issued while no poll is in flight; an index above 4 is ignored.
module touch_report_tracker (
    input  logic                               clk,
    input  logic                               rst_n,
    // poll input, s_tdata from bit 0: caller_mode, device_status, raw_a0, raw_b0,
    // raw_a1, raw_b1, raw_a2, raw_b2, raw_a3, raw_b3, raw_a4, raw_b4
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [trt_pkg::InDataW-1:0]        s_tdata,
    // point results, m_tdata from bit 0: point_index, point_x, point_y, touch_flags,
    // zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [trt_pkg::OutDataW-1:0]       m_tdata,
    // m_tuser from bit 0: scan_valid, clear_request, sampled
    output logic [trt_pkg::OutUserW-1:0]       m_tuser,
    output logic                               m_tlast,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [trt_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [trt_pkg::CfgDataW-1:0]       cfg_data
);

    trt_pkg::trt_cfg_t cfg_reg, cfg_next;
    trt_pkg::trt_cmd_t push_cmd, head;
    logic              push, room, pop, avail;

    assign cfg_ready = 1'b1;

    // register file decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                trt_pkg::CFG_SCAN_DIR: cfg_next.scan_dir   = cfg_data[1:0];
                trt_pkg::CFG_WIDTH:    cfg_next.width      = cfg_data;
                trt_pkg::CFG_HEIGHT:   cfg_next.height     = cfg_data;
                trt_pkg::CFG_SHORT:    cfg_next.short_side = cfg_data;
                trt_pkg::CFG_LONG:     cfg_next.long_side  = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_dir   <= trt_pkg::RstScanDir;
            cfg_reg.width      <= trt_pkg::RstWidth;
            cfg_reg.height     <= trt_pkg::RstHeight;
            cfg_reg.short_side <= trt_pkg::RstShort;
            cfg_reg.long_side  <= trt_pkg::RstLong;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify polls as they arrive
    trt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .cfg      (cfg_reg),
        .room     (room),
        .push     (push),
        .cmd      (push_cmd)
    );

    // decouples acceptance from result delivery
    trt_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .room     (room),
        .pop      (pop),
        .avail    (avail),
        .head     (head)
    );

    // apply slot updates and stream out the point results
    trt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule
